FILE: hdl/u2u8_pkg.sv
`timescale 1ns / 1ps

package u2u8_pkg;

    localparam logic [15:0] SURR_HI_MIN = 16'hD800;
    localparam logic [15:0] SURR_HI_MAX = 16'hDBFF;
    localparam logic [15:0] SURR_LO_MIN = 16'hDC00;
    localparam logic [15:0] SURR_LO_MAX = 16'hDFFF;
    localparam logic [20:0] SUPP_BASE   = 21'h10000;
    localparam logic [15:0] LIMIT_1B    = 16'h0080;
    localparam logic [15:0] LIMIT_2B    = 16'h0800;

    localparam logic [7:0] LEAD_2B   = 8'hC0;
    localparam logic [7:0] LEAD_3B   = 8'hE0;
    localparam logic [7:0] LEAD_4B   = 8'hF0;
    localparam logic [7:0] CONT_MARK = 8'h80;

    localparam logic [1:0] LEN_1B = 2'd0;
    localparam logic [1:0] LEN_2B = 2'd1;
    localparam logic [1:0] LEN_3B = 2'd2;
    localparam logic [1:0] LEN_4B = 2'd3;

    // One queued job: an optional flushed high surrogate, then an optional code point.
    typedef struct packed {
        logic        flush;
        logic [9:0]  flush_bits;
        logic        main;
        logic [20:0] cp;
        logic [1:0]  len_m1;
        logic        last;
    } job_t;

    function automatic logic [7:0] enc_byte(
        input logic [20:0] cp,
        input logic [1:0]  len_m1,
        input logic [1:0]  idx
    );
        logic [7:0] b;
        b = 8'd0;
        case (len_m1)
            LEN_1B: b = {1'b0, cp[6:0]};
            LEN_2B:
            begin
                if (idx == 2'd0)
                    b = LEAD_2B | {3'd0, cp[10:6]};
                else
                    b = CONT_MARK | {2'd0, cp[5:0]};
            end
            LEN_3B:
            begin
                case (idx)
                    2'd0:    b = LEAD_3B | {4'd0, cp[15:12]};
                    2'd1:    b = CONT_MARK | {2'd0, cp[11:6]};
                    default: b = CONT_MARK | {2'd0, cp[5:0]};
                endcase
            end
            default:
            begin
                case (idx)
                    2'd0:    b = LEAD_4B | {5'd0, cp[20:18]};
                    2'd1:    b = CONT_MARK | {2'd0, cp[17:12]};
                    2'd2:    b = CONT_MARK | {2'd0, cp[11:6]};
                    default: b = CONT_MARK | {2'd0, cp[5:0]};
                endcase
            end
        endcase
        return b;
    endfunction

endpackage

FILE: hdl/u2u8_front.sv
`timescale 1ns / 1ps

module u2u8_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [15:0]       code_unit,
    input  logic              last_unit,
    output logic              push,
    output u2u8_pkg::job_t    job
);

    logic       pend_valid_reg;
    logic       pend_valid_next;
    logic [9:0] pend_bits_reg;
    logic [9:0] pend_bits_next;
    logic       is_high;
    logic       is_low;

    always_comb
    begin
        is_high = code_unit inside {[u2u8_pkg::SURR_HI_MIN:u2u8_pkg::SURR_HI_MAX]};
        is_low  = code_unit inside {[u2u8_pkg::SURR_LO_MIN:u2u8_pkg::SURR_LO_MAX]};

        job.flush      = 1'b0;
        job.flush_bits = pend_bits_reg;
        job.main       = 1'b1;
        job.cp         = {5'd0, code_unit};
        job.last       = last_unit;
        pend_valid_next = pend_valid_reg;
        pend_bits_next  = pend_bits_reg;

        if (code_unit < u2u8_pkg::LIMIT_1B)
            job.len_m1 = u2u8_pkg::LEN_1B;
        else if (code_unit < u2u8_pkg::LIMIT_2B)
            job.len_m1 = u2u8_pkg::LEN_2B;
        else
            job.len_m1 = u2u8_pkg::LEN_3B;

        if (pend_valid_reg && is_low)
        begin
            job.cp     = u2u8_pkg::SUPP_BASE + {1'b0, pend_bits_reg, code_unit[9:0]};
            job.len_m1 = u2u8_pkg::LEN_4B;
            pend_valid_next = 1'b0;
            pend_bits_next  = 10'd0;
        end
        else
        begin
            job.flush = pend_valid_reg;
            if (is_high && !last_unit)
            begin
                job.main        = 1'b0;
                pend_valid_next = 1'b1;
                pend_bits_next  = code_unit[9:0];
            end
            else
            begin
                pend_valid_next = 1'b0;
                pend_bits_next  = 10'd0;
            end
        end

        push = accept && (job.flush || job.main);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            pend_bits_reg  <= 10'd0;
        end
        else if (accept)
        begin
            pend_valid_reg <= pend_valid_next;
            pend_bits_reg  <= pend_bits_next;
        end
    end

endmodule

FILE: hdl/u2u8_queue.sv
`timescale 1ns / 1ps

module u2u8_queue #(
    parameter int DEPTH = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  u2u8_pkg::job_t    push_job,
    input  logic              pop,
    output logic              full,
    output logic              head_valid,
    output u2u8_pkg::job_t    head_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    u2u8_pkg::job_t   entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    always_comb
    begin
        full       = (count_reg == CNT_W'(DEPTH));
        head_valid = (count_reg != '0);
        head_job   = entries_reg[rd_ptr_reg];
        do_push    = push && !full;
        do_pop     = pop && head_valid;

        wr_ptr_next = wr_ptr_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;

        rd_ptr_next = rd_ptr_reg;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;

        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entries_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: hdl/u2u8_back.sv
`timescale 1ns / 1ps

module u2u8_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  u2u8_pkg::job_t    head_job,
    output logic              pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,
    output logic              m_tlast,
    output logic              m_tuser
);

    logic        phase_reg;
    logic        phase_next;
    logic [1:0]  idx_reg;
    logic [1:0]  idx_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [7:0]  out_byte_reg;
    logic        out_last_reg;
    logic        out_end_reg;
    logic        eff_phase;
    logic [20:0] cur_cp;
    logic [1:0]  cur_len_m1;
    logic        final_byte;
    logic        job_done;
    logic        load;

    always_comb
    begin
        // Jobs without a flushed surrogate start directly on the code point.
        eff_phase  = phase_reg || !head_job.flush;
        cur_cp     = eff_phase ? head_job.cp
                               : {5'd0, u2u8_pkg::SURR_HI_MIN[15:10], head_job.flush_bits};
        cur_len_m1 = eff_phase ? head_job.len_m1 : u2u8_pkg::LEN_3B;
        final_byte = (idx_reg == cur_len_m1);
        job_done   = final_byte && (eff_phase || !head_job.main);
        load       = head_valid && (!out_valid_reg || m_tready);
        pop        = load && job_done;

        phase_next = phase_reg;
        idx_next   = idx_reg;
        if (load)
        begin
            if (job_done)
            begin
                phase_next = 1'b0;
                idx_next   = 2'd0;
            end
            else if (final_byte)
            begin
                phase_next = 1'b1;
                idx_next   = 2'd0;
            end
            else
                idx_next = idx_reg + 1'b1;
        end

        if (load)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= 1'b0;
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg <= u2u8_pkg::enc_byte(cur_cp, cur_len_m1, idx_reg);
            out_last_reg <= job_done;
            out_end_reg  <= job_done && head_job.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_end_reg;

endmodule

FILE: hdl/utf16_to_utf8_encoder_top.sv
`timescale 1ns / 1ps

// Channel  Dir  tdata (low bit up)     tlast       tuser
// s_*      in   code_unit[15:0]        last_unit   -
// m_*      out  utf8_byte[7:0]         run_last    message_end
//
// One UTF-8 byte leaves per cycle while the queue holds a job and m_tready is high.
// A code unit gives 1 to 3 bytes, 4 for a pair, up to 6 when a surrogate is flushed.
// A unit that only becomes pending gives no beat.
// A unit's job is registered in the queue, then its bytes in the output register; the
// job queue of QUEUE_DEPTH entries lets input run ahead while output is stalled.
// Reset clears the pending surrogate, the queue and the output valid flag.

module utf16_to_utf8_encoder_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,  // code_unit[15:0]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,  // utf8_byte[7:0]
    output logic        m_tlast,
    output logic        m_tuser   // message_end
);

    logic           q_full;
    logic           q_push;
    logic           q_pop;
    logic           q_head_valid;
    u2u8_pkg::job_t push_job;
    u2u8_pkg::job_t head_job;
    logic           accept;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    u2u8_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .code_unit (s_tdata),
        .last_unit (s_tlast),
        .push      (q_push),
        .job       (push_job)
    );

    u2u8_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_job   (push_job),
        .pop        (q_pop),
        .full       (q_full),
        .head_valid (q_head_valid),
        .head_job   (head_job)
    );

    u2u8_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_head_valid),
        .head_job   (head_job),
        .pop        (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

endmodule

FILE: hdl/u2u8_checker.sv
`timescale 1ns / 1ps

module u2u8_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic        m_tlast,
    input logic        m_tuser
);

    // A stalled output beat keeps its contents.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
            && $stable(m_tuser))
        else $error("output beat changed while stalled");

    // The end of a message is always the last byte of its unit.
    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("message end without run end");

    // A single-byte sequence always closes the run of its unit.
    a_ascii_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[7] |-> m_tlast)
        else $error("single-byte sequence not marked last");

    // A lead byte never closes a run.
    a_lead_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[7] && m_tdata[6] |-> !m_tlast)
        else $error("lead byte marked last");

endmodule

bind utf16_to_utf8_encoder_top u2u8_checker u_u2u8_checker (.*);

FILE: dv/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 24;

    typedef struct {
        logic [7:0] data;
        logic       run_last;
        logic       msg_end;
    } utf8_beat_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = 16'h0000;  // code_unit[15:0]
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;              // utf8_byte[7:0]
    logic        m_tlast;
    logic        m_tuser;              // message_end

    utf8_beat_t  utf8_expect_q[$];
    logic        hi_held = 1'b0;
    logic [9:0]  hi_bits = 10'd0;
    logic [7:0]  enc_bytes[6];
    int          enc_count;

    bit          src_idle_on  = 1'b1;
    bit          sink_idle_on = 1'b1;
    int          stall_left   = 0;
    int          units_sent   = 0;
    int          pairs_sent   = 0;
    int          beats_seen   = 0;
    int          mismatches   = 0;
    int          cycle_count  = 0;

    utf16_to_utf8_encoder_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d bytes outstanding.",
                     cycle_count, utf8_expect_q.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic void add_byte(input logic [7:0] b);
        enc_bytes[enc_count] = b;
        enc_count++;
    endfunction

    function automatic void add_point(input logic [20:0] cp);
        if (cp < 21'h80)
        begin
            add_byte({1'b0, cp[6:0]});
        end
        else if (cp < 21'h800)
        begin
            add_byte(u2u8_pkg::LEAD_2B | {3'd0, cp[10:6]});
            add_byte(u2u8_pkg::CONT_MARK | {2'd0, cp[5:0]});
        end
        else if (cp < u2u8_pkg::SUPP_BASE)
        begin
            add_byte(u2u8_pkg::LEAD_3B | {4'd0, cp[15:12]});
            add_byte(u2u8_pkg::CONT_MARK | {2'd0, cp[11:6]});
            add_byte(u2u8_pkg::CONT_MARK | {2'd0, cp[5:0]});
        end
        else
        begin
            add_byte(u2u8_pkg::LEAD_4B | {5'd0, cp[20:18]});
            add_byte(u2u8_pkg::CONT_MARK | {2'd0, cp[17:12]});
            add_byte(u2u8_pkg::CONT_MARK | {2'd0, cp[11:6]});
            add_byte(u2u8_pkg::CONT_MARK | {2'd0, cp[5:0]});
        end
    endfunction

    // Updates the held surrogate and queues the bytes that one code unit causes.
    function automatic void predict_unit(input logic [15:0] cu, input logic lu);
        logic is_hi;
        logic is_lo;
        is_hi = (cu >= u2u8_pkg::SURR_HI_MIN) && (cu <= u2u8_pkg::SURR_HI_MAX);
        is_lo = (cu >= u2u8_pkg::SURR_LO_MIN) && (cu <= u2u8_pkg::SURR_LO_MAX);
        enc_count = 0;
        if (hi_held && is_lo)
        begin
            add_point(u2u8_pkg::SUPP_BASE + {1'b0, hi_bits, cu[9:0]});
            hi_held = 1'b0;
        end
        else
        begin
            if (hi_held)
            begin
                add_point({5'd0, u2u8_pkg::SURR_HI_MIN | {6'd0, hi_bits}});
                hi_held = 1'b0;
            end
            if (is_hi && !lu)
            begin
                hi_held = 1'b1;
                hi_bits = cu[9:0];
            end
            else
            begin
                add_point({5'd0, cu});
            end
        end
        for (int i = 0; i < enc_count; i++)
            utf8_expect_q.push_back('{enc_bytes[i], i == enc_count - 1,
                                      lu && (i == enc_count - 1)});
    endfunction

    function automatic void log_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("Mismatch at %0t: %s", $time, msg);
    endfunction

    always @(posedge clk)
    begin
        utf8_beat_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            beats_seen++;
            if (utf8_expect_q.size() == 0)
            begin
                log_mismatch($sformatf("unexpected beat byte=%02h last=%0b end=%0b",
                                       m_tdata, m_tlast, m_tuser));
            end
            else
            begin
                want = utf8_expect_q.pop_front();
                if (m_tdata !== want.data || m_tlast !== want.run_last
                    || m_tuser !== want.msg_end)
                    log_mismatch($sformatf(
                        "expected byte=%02h last=%0b end=%0b, got byte=%02h last=%0b end=%0b",
                        want.data, want.run_last, want.msg_end, m_tdata, m_tlast, m_tuser));
            end
        end
        if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if (sink_idle_on && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(1, 18) - 1;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    task automatic send_unit(input logic [15:0] cu, input logic lu);
        logic ready_seen;
        if (src_idle_on && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= cu;
        s_tlast  <= lu;
        do
        begin
            @(negedge clk);
            ready_seen = s_tready;
            @(posedge clk);
        end
        while (!ready_seen);
        predict_unit(cu, lu);
        units_sent++;
    endtask

    // Mostly well-formed text with some lone surrogates and arbitrary units mixed in.
    task automatic send_random_char(output int n_units);
        int          kind;
        logic        lu;
        logic [15:0] cu;
        kind = $urandom_range(0, 19);
        lu = ($urandom_range(0, 9) == 0);
        n_units = 1;
        if (kind < 4)
        begin
            cu = 16'($urandom_range(16'h0000, 16'h007F));
        end
        else if (kind < 7)
        begin
            cu = 16'($urandom_range(16'h0080, 16'h07FF));
        end
        else if (kind < 10)
        begin
            if ($urandom_range(0, 1) == 0)
                cu = 16'($urandom_range(16'h0800, 16'hD7FF));
            else
                cu = 16'($urandom_range(16'hE000, 16'hFFFF));
        end
        else if (kind < 16)
        begin
            send_unit(16'($urandom_range(u2u8_pkg::SURR_HI_MIN, u2u8_pkg::SURR_HI_MAX)),
                      1'b0);
            cu = 16'($urandom_range(u2u8_pkg::SURR_LO_MIN, u2u8_pkg::SURR_LO_MAX));
            pairs_sent++;
            n_units = 2;
        end
        else if (kind < 18)
        begin
            cu = 16'($urandom_range(u2u8_pkg::SURR_HI_MIN, u2u8_pkg::SURR_HI_MAX));
        end
        else if (kind < 19)
        begin
            cu = 16'($urandom_range(u2u8_pkg::SURR_LO_MIN, u2u8_pkg::SURR_LO_MAX));
        end
        else
        begin
            cu = 16'($urandom_range(0, 16'hFFFF));
        end
        send_unit(cu, lu);
    endtask

    task automatic test_bmp_boundaries();
        send_unit(16'h0000, 1'b0);
        send_unit(16'h007F, 1'b0);
        send_unit(16'h0080, 1'b0);
        send_unit(16'h07FF, 1'b0);
        send_unit(16'h0800, 1'b0);
        send_unit(16'hD7FF, 1'b0);
        send_unit(16'hE000, 1'b0);
        send_unit(16'hFFFF, 1'b1);
    endtask

    task automatic test_surrogate_pairs();
        send_unit(16'hD800, 1'b0);
        send_unit(16'hDC00, 1'b0);
        send_unit(16'hDBFF, 1'b0);
        send_unit(16'hDFFF, 1'b1);
    endtask

    task automatic test_surrogate_corners();
        // A high surrogate that ends the message is encoded at once.
        send_unit(16'hDABC, 1'b1);
        send_unit(16'hDABC, 1'b0);
        send_unit(16'h0041, 1'b1);
        // A flushed surrogate followed by a three-byte unit gives six beats.
        send_unit(16'hDBFF, 1'b0);
        send_unit(16'hFFFF, 1'b0);
        send_unit(16'hD800, 1'b0);
        send_unit(16'hDBFF, 1'b0);
        send_unit(16'hDC00, 1'b0);
        send_unit(16'hDC00, 1'b0);
        send_unit(16'hDFFF, 1'b0);
        send_unit(16'hD801, 1'b0);
        send_unit(16'hD802, 1'b1);
    endtask

    task automatic test_random_text(input int n_items);
        int sent;
        int n;
        sent = 0;
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        while (sent < n_items)
        begin
            send_random_char(n);
            sent += n;
        end
    endtask

    task automatic test_steady_stream(input int n_items);
        int sent;
        int n;
        sent = 0;
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        while (sent < n_items)
        begin
            send_random_char(n);
            sent += n;
        end
        send_unit(16'($urandom_range(0, 16'hFFFF)), 1'b1);
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_bmp_boundaries();
        test_surrogate_pairs();
        test_surrogate_corners();
        test_random_text(145);
        test_steady_stream(40);

        s_tvalid <= 1'b0;
        while (utf8_expect_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (utf8_expect_q.size() != 0)
            log_mismatch($sformatf("%0d bytes never arrived", utf8_expect_q.size()));

        $display("Sent %0d code units including %0d surrogate pairs; checked %0d bytes.",
                 units_sent, pairs_sent, beats_seen);
        $display("Covered range boundaries, paired, flushed and lone surrogates, stalls.");
        if (mismatches == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("%0d mismatches in total.", mismatches);
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

FILE: files.f
hdl/u2u8_pkg.sv
hdl/u2u8_front.sv
hdl/u2u8_queue.sv
hdl/u2u8_back.sv
hdl/utf16_to_utf8_encoder_top.sv
hdl/u2u8_checker.sv
dv/tb.sv
